// File: hw/rtl/bba_pkg.sv
// shared constants, codes and control types of the buddy block allocator
package bba_pkg;

    localparam int UNITS_LOG2 = 16;
    localparam int MIN_LOG2   = 6;
    localparam int NUM_ORDERS = 17;
    localparam int TOP_ORDER  = NUM_ORDERS - 1;
    localparam int HDR_BYTES  = 32;

    localparam int UNIT_W = UNITS_LOG2;
    localparam int LINK_W = UNITS_LOG2 + 1;
    localparam int ORD_W  = 5;
    localparam int OFF_W  = 22;
    localparam int CNT_W  = 17;
    localparam int REQ_W  = 31;
    localparam int POOL_W = 23;

    localparam logic [LINK_W-1:0] NO_LINK = LINK_W'(1) << UNITS_LOG2;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_TOOBIG = 2'd1,
        ST_NOBLK  = 2'd2,
        ST_BADFREE = 2'd3
    } t_status;

    typedef enum logic [4:0] {
        OP_NONE, OP_CLR, OP_CARVE, OP_LOAD, OP_SIZE, OP_SRCH, OP_ARD, OP_AUNL,
        OP_SPLIT, OP_AFIN, OP_FRD, OP_FSET, OP_MRD, OP_MUNL, OP_PUSH0, OP_PUSH1,
        OP_FAIL, OP_EMIT
    } t_op;

    typedef struct packed {
        t_op     op;
        t_status code;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic carve_last;
        logic size_big;
        logic size_fit;
        logic srch_end;
        logic srch_hit;
        logic split_done;
        logic free_ok;
        logic flag_ok;
        logic merge_stop;
        logic buddy_ok;
        logic can_emit;
    } t_sts;

endpackage

// File: hw/rtl/bba_ctrl.sv
// sequencer of the buddy block allocator
module bba_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic            i_s_valid,
    input  logic            i_s_type,
    input  bba_pkg::t_sts   i_sts,
    output bba_pkg::t_cmd   o_cmd,
    output logic            o_s_ready
);

    typedef enum logic [15:0] {
        S_CLR   = 16'h0001,
        S_CARVE = 16'h0002,
        S_IDLE  = 16'h0004,
        S_SIZE  = 16'h0008,
        S_SRCH  = 16'h0010,
        S_ARD   = 16'h0020,
        S_AUNL  = 16'h0040,
        S_SPLIT = 16'h0080,
        S_AFIN  = 16'h0100,
        S_FRD   = 16'h0200,
        S_FCHK  = 16'h0400,
        S_MRD   = 16'h0800,
        S_MCHK  = 16'h1000,
        S_PUSH0 = 16'h2000,
        S_PUSH1 = 16'h4000,
        S_DONE  = 16'h8000
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_s_ready = (r_state == S_IDLE) && !i_cfg_we;

    always_comb begin
        n_state    = r_state;
        o_cmd.op   = bba_pkg::OP_NONE;
        o_cmd.code = bba_pkg::ST_OK;
        case (r_state)
            S_CLR: begin
                o_cmd.op = bba_pkg::OP_CLR;
                if (i_sts.clr_last) n_state = S_CARVE;
            end
            S_CARVE: begin
                o_cmd.op = bba_pkg::OP_CARVE;
                if (i_sts.carve_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_s_valid) begin
                    o_cmd.op = bba_pkg::OP_LOAD;
                    n_state  = i_s_type ? S_FRD : S_SIZE;
                end
            end
            S_SIZE: begin
                if (i_sts.size_big) begin
                    o_cmd.op   = bba_pkg::OP_FAIL;
                    o_cmd.code = bba_pkg::ST_TOOBIG;
                    n_state    = S_DONE;
                end else begin
                    o_cmd.op = bba_pkg::OP_SIZE;
                    if (i_sts.size_fit) n_state = S_SRCH;
                end
            end
            S_SRCH: begin
                if (i_sts.srch_end) begin
                    o_cmd.op   = bba_pkg::OP_FAIL;
                    o_cmd.code = bba_pkg::ST_NOBLK;
                    n_state    = S_DONE;
                end else begin
                    o_cmd.op = bba_pkg::OP_SRCH;
                    if (i_sts.srch_hit) n_state = S_ARD;
                end
            end
            S_ARD: begin
                o_cmd.op = bba_pkg::OP_ARD;
                n_state  = S_AUNL;
            end
            S_AUNL: begin
                o_cmd.op = bba_pkg::OP_AUNL;
                n_state  = S_SPLIT;
            end
            S_SPLIT: begin
                o_cmd.op = bba_pkg::OP_SPLIT;
                if (i_sts.split_done) n_state = S_AFIN;
            end
            S_AFIN: begin
                o_cmd.op = bba_pkg::OP_AFIN;
                n_state  = S_DONE;
            end
            S_FRD: begin
                if (i_sts.free_ok) begin
                    o_cmd.op = bba_pkg::OP_FRD;
                    n_state  = S_FCHK;
                end else begin
                    o_cmd.op   = bba_pkg::OP_FAIL;
                    o_cmd.code = bba_pkg::ST_BADFREE;
                    n_state    = S_DONE;
                end
            end
            S_FCHK: begin
                if (i_sts.flag_ok) begin
                    o_cmd.op = bba_pkg::OP_FSET;
                    n_state  = S_MRD;
                end else begin
                    o_cmd.op   = bba_pkg::OP_FAIL;
                    o_cmd.code = bba_pkg::ST_BADFREE;
                    n_state    = S_DONE;
                end
            end
            S_MRD: begin
                if (i_sts.merge_stop) begin
                    n_state = S_PUSH0;
                end else begin
                    o_cmd.op = bba_pkg::OP_MRD;
                    n_state  = S_MCHK;
                end
            end
            S_MCHK: begin
                if (i_sts.buddy_ok) begin
                    o_cmd.op = bba_pkg::OP_MUNL;
                    n_state  = S_MRD;
                end else begin
                    n_state = S_PUSH0;
                end
            end
            S_PUSH0: begin
                o_cmd.op = bba_pkg::OP_PUSH0;
                n_state  = S_PUSH1;
            end
            S_PUSH1: begin
                o_cmd.op = bba_pkg::OP_PUSH1;
                n_state  = S_DONE;
            end
            S_DONE: begin
                if (i_sts.can_emit) begin
                    o_cmd.op = bba_pkg::OP_EMIT;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: hw/rtl/bba_dp.sv
// datapath: unit tables, list heads, counters and result registers
module bba_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [bba_pkg::POOL_W-1:0]    i_cfg_wdata,
    input  logic [bba_pkg::REQ_W-1:0]     i_req_bytes,
    input  logic [bba_pkg::OFF_W-1:0]     i_free_offset,
    input  bba_pkg::t_cmd                 i_cmd,
    output bba_pkg::t_sts                 o_sts,
    input  logic                          i_m_ready,
    output logic                          o_m_valid,
    output logic [1:0]                    o_m_status,
    output logic [bba_pkg::OFF_W-1:0]     o_m_offset,
    output logic [bba_pkg::CNT_W-1:0]     o_m_count
);

    localparam int UW = bba_pkg::UNIT_W;
    localparam int LW = bba_pkg::LINK_W;
    localparam int KW = bba_pkg::ORD_W;
    localparam int FW = KW + 2;
    localparam int UNITS = 1 << UW;

    // unit tables: flags {start, free, order}, prev link, next link
    logic [FW-1:0] mem_flag [UNITS];
    logic [LW-1:0] mem_prev [UNITS];
    logic [LW-1:0] mem_next [UNITS];

    logic          flag_we, prev_we, next_we;
    logic [UW-1:0] flag_wa, prev_wa, next_wa, rd_a;
    logic [FW-1:0] flag_wd;
    logic [LW-1:0] prev_wd, next_wd;
    logic [FW-1:0] r_rd_flag;
    logic [LW-1:0] r_rd_prev, r_rd_next;

    logic [LW-1:0]             r_head [bba_pkg::NUM_ORDERS];
    logic [LW-1:0]             r_pool_units;
    logic [UW-1:0]             r_clr;
    logic [KW-1:0]             r_k;
    logic [KW-1:0]             r_want;
    logic [31:0]               r_need;
    logic [UW-1:0]             r_u;
    logic [UW-1:0]             r_b;
    logic [LW-1:0]             r_h;
    logic [LW-1:0]             r_at;
    logic [bba_pkg::OFF_W-1:0] r_fo;
    logic [bba_pkg::CNT_W-1:0] r_count;
    logic [1:0]                r_res_status;
    logic [bba_pkg::OFF_W-1:0] r_res_off;
    logic                      r_out_valid;
    logic [1:0]                r_out_status;
    logic [bba_pkg::OFF_W-1:0] r_out_off;
    logic [bba_pkg::CNT_W-1:0] r_out_count;

    logic [bba_pkg::OFF_W-1:0] start_b, in_start;
    logic [LW-1:0]             head_sel;
    logic [UW-1:0]             bmask, buddy, split_addr;
    logic [KW-1:0]             k_dec, ord_clamp;
    logic [32:0]               pow_sz;
    logic [LW-1:0]             pool_in;

    assign start_b  = r_fo - bba_pkg::OFF_W'(bba_pkg::HDR_BYTES);
    assign in_start = i_free_offset - bba_pkg::OFF_W'(bba_pkg::HDR_BYTES);
    assign head_sel = (r_k < KW'(bba_pkg::NUM_ORDERS)) ? r_head[r_k] : bba_pkg::NO_LINK;
    assign bmask    = UW'(1) << r_k;
    assign buddy    = r_u ^ bmask;
    assign k_dec    = r_k - KW'(1);
    assign split_addr = r_u + (UW'(1) << k_dec);
    assign pow_sz   = 33'(1) << (r_want + KW'(bba_pkg::MIN_LOG2));
    assign ord_clamp = (r_rd_flag[KW-1:0] > KW'(bba_pkg::TOP_ORDER)) ?
                       KW'(bba_pkg::TOP_ORDER) : r_rd_flag[KW-1:0];
    // sizes above the largest pool count as the largest pool
    assign pool_in  = i_cfg_wdata[bba_pkg::POOL_W-1] ? bba_pkg::NO_LINK
                    : i_cfg_wdata[bba_pkg::POOL_W-1:bba_pkg::MIN_LOG2];

    always_comb begin
        o_sts.clr_last   = (r_clr == '1);
        o_sts.carve_last = (r_k == '0);
        o_sts.size_big   = (r_want == KW'(bba_pkg::NUM_ORDERS));
        o_sts.size_fit   = (pow_sz >= {1'b0, r_need});
        o_sts.srch_end   = (r_k >= KW'(bba_pkg::NUM_ORDERS));
        o_sts.srch_hit   = !head_sel[LW-1];
        o_sts.split_done = (r_k == r_want);
        o_sts.free_ok    = (r_fo >= bba_pkg::OFF_W'(bba_pkg::HDR_BYTES))
                        && (start_b[bba_pkg::MIN_LOG2-1:0] == '0)
                        && ({1'b0, start_b[bba_pkg::OFF_W-1:bba_pkg::MIN_LOG2]} < r_pool_units);
        o_sts.flag_ok    = r_rd_flag[FW-1] && !r_rd_flag[FW-2];
        o_sts.merge_stop = (r_k >= KW'(bba_pkg::TOP_ORDER)) || ({1'b0, buddy} >= r_pool_units);
        o_sts.buddy_ok   = (r_rd_flag == {2'b11, r_k});
        o_sts.can_emit   = !r_out_valid || i_m_ready;
    end

    // table port control per datapath step
    always_comb begin
        flag_we = 1'b0; flag_wa = '0; flag_wd = '0;
        prev_we = 1'b0; prev_wa = '0; prev_wd = '0;
        next_we = 1'b0; next_wa = '0; next_wd = '0;
        rd_a    = r_u;
        case (i_cmd.op)
            bba_pkg::OP_CLR: begin
                flag_we = 1'b1; flag_wa = r_clr;
            end
            bba_pkg::OP_CARVE: begin
                flag_we = r_pool_units[r_k]; flag_wa = r_at[UW-1:0]; flag_wd = {2'b11, r_k};
                prev_we = r_pool_units[r_k]; prev_wa = r_at[UW-1:0]; prev_wd = bba_pkg::NO_LINK;
                next_we = r_pool_units[r_k]; next_wa = r_at[UW-1:0]; next_wd = bba_pkg::NO_LINK;
            end
            bba_pkg::OP_AUNL: begin
                prev_we = !r_rd_next[LW-1]; prev_wa = r_rd_next[UW-1:0];
                prev_wd = bba_pkg::NO_LINK;
            end
            bba_pkg::OP_SPLIT: begin
                if (!o_sts.split_done) begin
                    flag_we = 1'b1; flag_wa = split_addr; flag_wd = {2'b11, k_dec};
                    prev_we = 1'b1; prev_wa = split_addr; prev_wd = bba_pkg::NO_LINK;
                    next_we = 1'b1; next_wa = split_addr; next_wd = bba_pkg::NO_LINK;
                end
            end
            bba_pkg::OP_AFIN: begin
                flag_we = 1'b1; flag_wa = r_u; flag_wd = {2'b10, r_want};
            end
            bba_pkg::OP_MRD: begin
                rd_a = buddy;
            end
            bba_pkg::OP_MUNL: begin
                next_we = !r_rd_prev[LW-1]; next_wa = r_rd_prev[UW-1:0]; next_wd = r_rd_next;
                prev_we = !r_rd_next[LW-1]; prev_wa = r_rd_next[UW-1:0]; prev_wd = r_rd_prev;
                flag_we = 1'b1; flag_wa = (r_b > r_u) ? r_b : r_u;
            end
            bba_pkg::OP_PUSH0: begin
                flag_we = 1'b1; flag_wa = r_u; flag_wd = {2'b11, r_k};
                prev_we = 1'b1; prev_wa = r_u; prev_wd = bba_pkg::NO_LINK;
                next_we = 1'b1; next_wa = r_u; next_wd = head_sel;
            end
            bba_pkg::OP_PUSH1: begin
                prev_we = !r_h[LW-1]; prev_wa = r_h[UW-1:0]; prev_wd = {1'b0, r_u};
            end
            default: begin
                rd_a = r_u;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (flag_we) mem_flag[flag_wa] <= flag_wd;
        if (prev_we) mem_prev[prev_wa] <= prev_wd;
        if (next_we) mem_next[next_wa] <= next_wd;
        r_rd_flag <= mem_flag[rd_a];
        r_rd_prev <= mem_prev[rd_a];
        r_rd_next <= mem_next[rd_a];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we) begin
            r_pool_units <= i_rst_n ? pool_in : '0;
            r_clr   <= '0;
            r_k     <= KW'(bba_pkg::TOP_ORDER);
            r_at    <= '0;
            r_count <= '0;
            for (int i = 0; i < bba_pkg::NUM_ORDERS; i++) r_head[i] <= bba_pkg::NO_LINK;
        end else begin
            case (i_cmd.op)
                bba_pkg::OP_CLR: begin
                    r_clr <= r_clr + UW'(1);
                end
                bba_pkg::OP_CARVE: begin
                    if (r_pool_units[r_k]) begin
                        r_head[r_k] <= r_at;
                        r_at        <= r_at + (LW'(1) << r_k);
                    end
                    r_k <= k_dec;
                end
                bba_pkg::OP_LOAD: begin
                    r_need <= {1'b0, i_req_bytes} + 32'(bba_pkg::HDR_BYTES);
                    r_want <= '0;
                    r_fo   <= i_free_offset;
                    r_u    <= in_start[bba_pkg::OFF_W-1:bba_pkg::MIN_LOG2];
                end
                bba_pkg::OP_SIZE: begin
                    r_k <= r_want;
                    if (!o_sts.size_fit) r_want <= r_want + KW'(1);
                end
                bba_pkg::OP_SRCH: begin
                    if (o_sts.srch_hit) r_u <= head_sel[UW-1:0];
                    else r_k <= r_k + KW'(1);
                end
                bba_pkg::OP_AUNL: begin
                    r_head[r_k] <= r_rd_next;
                end
                bba_pkg::OP_SPLIT: begin
                    if (!o_sts.split_done) begin
                        r_head[k_dec] <= {1'b0, split_addr};
                        r_k <= k_dec;
                    end
                end
                bba_pkg::OP_AFIN: begin
                    r_count      <= r_count + bba_pkg::CNT_W'(1);
                    r_res_status <= bba_pkg::ST_OK;
                    r_res_off    <= {r_u, bba_pkg::MIN_LOG2'(0)}
                                  + bba_pkg::OFF_W'(bba_pkg::HDR_BYTES);
                end
                bba_pkg::OP_FSET: begin
                    r_k <= ord_clamp;
                end
                bba_pkg::OP_MRD: begin
                    r_b <= buddy;
                end
                bba_pkg::OP_MUNL: begin
                    if (r_rd_prev[LW-1]) r_head[r_k] <= r_rd_next;
                    if (r_b < r_u) r_u <= r_b;
                    r_k <= r_k + KW'(1);
                end
                bba_pkg::OP_PUSH0: begin
                    r_h         <= head_sel;
                    r_head[r_k] <= {1'b0, r_u};
                end
                bba_pkg::OP_PUSH1: begin
                    if (r_count != '0) r_count <= r_count - bba_pkg::CNT_W'(1);
                    r_res_status <= bba_pkg::ST_OK;
                    r_res_off    <= '0;
                end
                bba_pkg::OP_FAIL: begin
                    r_res_status <= i_cmd.code;
                    r_res_off    <= '0;
                end
                default: begin
                    r_clr <= r_clr;
                end
            endcase
        end
    end

    // output register, independent of the work sequence
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.op == bba_pkg::OP_EMIT) begin
            r_out_valid <= 1'b1;
        end else if (i_m_ready) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.op == bba_pkg::OP_EMIT) begin
            r_out_status <= r_res_status;
            r_out_off    <= r_res_off;
            r_out_count  <= r_count;
        end
    end

    assign o_m_valid  = r_out_valid;
    assign o_m_status = r_out_status;
    assign o_m_offset = r_out_off;
    assign o_m_count  = r_out_count;

endmodule

// File: hw/rtl/buddy_block_allocator.sv
// top level of the buddy block allocator: sequencer plus datapath
//
//  channel   direction  payload
//  s (in)    slave      tdata {free_offset, request_bytes}, tuser req_type
//  m (out)   master     tdata {allocated_count, block_offset, status}
//  cfg       write      pool_bytes
//
// per item, the size loop, the order search, the split loop and the merge loop
// each step once per order through the unit tables
// a merge step is a table read, then an unlink write
// after reset and after every pool_bytes write a clearing pass walks all 65536
// unit flag entries, one per cycle, then carves all 17 orders; no item is taken then
// a finished result waits in the output register while the next item is worked
module buddy_block_allocator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [22:0] i_cfg_wdata,   // pool_bytes
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [55:0] i_s_tdata,     // [30:0] request_bytes, [52:31] free_offset
    input  logic        i_s_tuser,     // req_type
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [47:0] o_m_tdata      // [1:0] status, [23:2] block_offset,
                                       // [40:24] allocated_count
);

    bba_pkg::t_cmd cmd;
    bba_pkg::t_sts sts;

    logic [1:0]                m_status;
    logic [bba_pkg::OFF_W-1:0] m_offset;
    logic [bba_pkg::CNT_W-1:0] m_count;

    // sequencer: one state per table step
    bba_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_s_valid (i_s_tvalid),
        .i_s_type  (i_s_tuser),
        .i_sts     (sts),
        .o_cmd     (cmd),
        .o_s_ready (o_s_tready)
    );

    // tables, list heads, live count and output register
    bba_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_req_bytes   (i_s_tdata[30:0]),
        .i_free_offset (i_s_tdata[52:31]),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_m_ready     (i_m_tready),
        .o_m_valid     (o_m_tvalid),
        .o_m_status    (m_status),
        .o_m_offset    (m_offset),
        .o_m_count     (m_count)
    );

    assign o_m_tdata = {7'd0, m_count, m_offset, m_status};

`ifndef SYNTHESIS
    // only a successful allocate carries an offset
    a_off_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tdata[1:0] != bba_pkg::ST_OK) |-> (o_m_tdata[23:2] == '0))
        else $error("offset on failed item");

    // an allocated offset sits just past a header on a unit boundary
    a_off_align: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tdata[23:2] != '0) |->
            (o_m_tdata[7:2] == 6'(bba_pkg::HDR_BYTES)))
        else $error("misaligned block offset");

    // a new result only comes out of work, never while idle
    a_emit_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(!o_s_tready))
        else $error("result while idle");
`endif

endmodule
